FILE: rtl/core/vsd_pkg.sv
// shared types and constants for the varint sign decoder
// no dependencies; used by every module in rtl/core
package vsd_pkg;

	// value kind codes, sampled on the first byte of a value
	localparam logic [1:0] KIND_U32 = 2'd0;
	localparam logic [1:0] KIND_U64 = 2'd1;
	localparam logic [1:0] KIND_S32 = 2'd2;

	// byte limits per kind
	localparam logic [3:0] LIMIT_32 = 4'd5;
	localparam logic [3:0] LIMIT_64 = 4'd9;

	localparam int ACC_W   = 63;
	localparam int SVAL_W  = 32;
	localparam int COUNT_W = 4;

	// one input request as held in the input register
	typedef struct packed {
		logic [7:0] in_byte;
		logic [1:0] value_kind;
	} item_t;

	// one decoded value
	typedef struct packed {
		logic [ACC_W-1:0]   unsigned_value;
		logic [SVAL_W-1:0]  signed_value;
		logic [COUNT_W-1:0] byte_count;
	} result_t;

endpackage

FILE: rtl/core/vsd_in_reg.sv
// input register stage of the varint sign decoder
// depends on vsd_pkg for the item type
module vsd_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  vsd_pkg::item_t in_item,
	input  logic          advance,
	output logic          valid_s1,
	output vsd_pkg::item_t item_s1
);

	logic load;

	// stall only while a held request cannot move on
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	// valid flag of the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= in_item;
		end
	end

endmodule

FILE: rtl/core/vsd_accum.sv
// group accumulator and result formatting of the varint sign decoder
// depends on vsd_pkg for kind codes, limits and the item and result types
module vsd_accum (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  vsd_pkg::item_t    item,
	output logic              done,
	output vsd_pkg::result_t  result
);

	logic [vsd_pkg::ACC_W-1:0]   acc_q;
	logic [vsd_pkg::COUNT_W-1:0] grp_q;
	logic [1:0]                  kind_q;
	logic                        busy_q;

	logic [1:0]                  kind_eff;
	logic [vsd_pkg::ACC_W-1:0]   acc_base;
	logic [vsd_pkg::COUNT_W-1:0] grp_base;
	logic [5:0]                  shamt;
	logic [vsd_pkg::ACC_W-1:0]   shifted;
	logic [vsd_pkg::ACC_W-1:0]   acc_new;
	logic [vsd_pkg::COUNT_W-1:0] grp_new;
	logic [vsd_pkg::COUNT_W-1:0] limit;
	logic [vsd_pkg::SVAL_W-1:0]  mag;

	// first byte of a value starts from a clean accumulator
	always_comb begin
		kind_eff = busy_q ? kind_q : item.value_kind;
		acc_base = busy_q ? acc_q : '0;
		grp_base = busy_q ? grp_q : '0;
	end

	// place the data group at 7 bits per byte taken so far
	assign shamt   = {grp_base[2:0], 3'b000} - {2'b00, grp_base};
	assign shifted = {{(vsd_pkg::ACC_W-7){1'b0}}, item.in_byte[6:0]} << shamt;
	assign acc_new = acc_base | shifted;
	assign grp_new = grp_base + 4'd1;

	// value ends on a clear continuation bit or at the byte limit
	assign limit = (kind_eff == vsd_pkg::KIND_U32) ? vsd_pkg::LIMIT_32 : vsd_pkg::LIMIT_64;
	assign done  = !(item.in_byte[7] && (grp_new < limit));

	// sign-magnitude: bit 0 is the sign, low 32 bits of the magnitude kept
	assign mag = acc_new[vsd_pkg::SVAL_W:1];

	// result formatting per kind
	always_comb begin
		result.byte_count = grp_new;
		case (kind_eff)
			vsd_pkg::KIND_U32: begin
				result.unsigned_value = {{(vsd_pkg::ACC_W-32){1'b0}}, acc_new[31:0]};
				result.signed_value   = '0;
			end
			vsd_pkg::KIND_S32: begin
				result.unsigned_value = '0;
				result.signed_value   = acc_new[0] ? (~mag + 32'd1) : mag;
			end
			default: begin
				result.unsigned_value = acc_new;
				result.signed_value   = '0;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			grp_q  <= '0;
			kind_q <= vsd_pkg::KIND_U32;
		end else if (step) begin
			busy_q <= !done;
			grp_q  <= done ? '0 : grp_new;
			kind_q <= kind_eff;
		end
	end

	// accumulator; only read while busy so it needs no reset
	always_ff @(posedge clk) begin
		if (step) begin
			acc_q <= acc_new;
		end
	end

endmodule

FILE: rtl/core/vsd_out_reg.sv
// result register of the varint sign decoder
// depends on vsd_pkg for the result type
module vsd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  vsd_pkg::result_t res_in,
	output logic             free,
	output logic             out_valid,
	input  logic             out_stall,
	output vsd_pkg::result_t res_q
);

	// room when empty or when the held result leaves this cycle
	assign free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (free) begin
			out_valid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res_in;
		end
	end

endmodule

FILE: rtl/core/varint_sign_decoder.sv
// Varint (LEB128 style) decoder taking one byte per request. Each byte is registered at the
// input, then its 7 data bits are merged into the accumulator and, when the value ends
// (clear continuation bit, or 5 bytes for unsigned 32-bit, 9 bytes otherwise), the decoded
// value is written to the result register. A new byte is accepted every cycle unless the
// result side stalls; the last byte of a value passes the input register, then the result
// register. value_kind is sampled on the first byte of each value; kind 3 decodes as kind 1.
// depends on vsd_pkg, vsd_in_reg, vsd_accum and vsd_out_reg
module varint_sign_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic [1:0]  value_kind,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [62:0] unsigned_value,
	output logic signed [31:0] signed_value,
	output logic [3:0]  byte_count
);

	vsd_pkg::item_t   in_item;
	vsd_pkg::item_t   item_s1;
	vsd_pkg::result_t res_comb;
	vsd_pkg::result_t res_q;
	logic             valid_s1;
	logic             out_free;
	logic             step;
	logic             done;

	assign in_item.in_byte    = in_byte;
	assign in_item.value_kind = value_kind;

	// held byte is consumed whenever the result side has room
	assign step = valid_s1 && out_free;

	// input register
	vsd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_item  (in_item),
		.advance  (out_free),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// accumulate and format
	vsd_accum u_accum (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.done   (done),
		.result (res_comb)
	);

	// result register
	vsd_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && done),
		.res_in    (res_comb),
		.free      (out_free),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_q     (res_q)
	);

	assign unsigned_value = res_q.unsigned_value;
	assign signed_value   = res_q.signed_value;
	assign byte_count     = res_q.byte_count;

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for varint_sign_decoder: byte stream in, decoded values out
// holds its own decoder model in a small scoreboard class; depends on vsd_pkg and the rtl
`timescale 1ns / 1ps

// tracks decoder state from accepted requests and holds the decoded values still due
class varint_tracker;
	vsd_pkg::result_t pending_values[$];
	logic [62:0] acc_bits;
	logic [3:0] groups_taken;
	logic [1:0] held_kind;
	bit mid_value;
	int mismatches;
	int values_checked;
	int kinds_seen[4];

	function new();
		acc_bits = '0;
		groups_taken = '0;
		held_kind = vsd_pkg::KIND_U32;
		mid_value = 1'b0;
		mismatches = 0;
		values_checked = 0;
		foreach (kinds_seen[i]) kinds_seen[i] = 0;
	endfunction

	// one accepted byte: merge its group and, when the value ends, queue the decoded value
	function void take_byte(logic [7:0] b, logic [1:0] k);
		logic [3:0] lim;
		logic [62:0] mag;
		vsd_pkg::result_t r;
		if (!mid_value) begin
			held_kind = k;
			acc_bits = '0;
			groups_taken = '0;
			mid_value = 1'b1;
		end
		lim = (held_kind == vsd_pkg::KIND_U32) ? vsd_pkg::LIMIT_32 : vsd_pkg::LIMIT_64;
		if (groups_taken < vsd_pkg::LIMIT_64)
			acc_bits = acc_bits | (63'(b[6:0]) << (7 * groups_taken));
		groups_taken = groups_taken + 4'd1;
		if (b[7] && groups_taken < lim)
			return;
		r.unsigned_value = '0;
		r.signed_value = '0;
		r.byte_count = groups_taken;
		case (held_kind)
			vsd_pkg::KIND_U32: begin
				r.unsigned_value = {31'd0, acc_bits[31:0]};
			end
			vsd_pkg::KIND_S32: begin
				// sign-magnitude: bit 0 is the sign, the rest the magnitude
				mag = acc_bits >> 1;
				if (acc_bits[0])
					mag = -mag;
				r.signed_value = mag[31:0];
			end
			default: begin
				r.unsigned_value = acc_bits;
			end
		endcase
		kinds_seen[held_kind]++;
		pending_values.push_back(r);
		mid_value = 1'b0;
		groups_taken = '0;
		acc_bits = '0;
	endfunction

	// one accepted result against the oldest value due
	function void match_value(logic [62:0] u, logic [31:0] s, logic [3:0] c);
		vsd_pkg::result_t want;
		values_checked++;
		if (pending_values.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result with nothing due: u=%h s=%h count=%0d", $realtime, u, s, c);
			return;
		end
		want = pending_values.pop_front();
		if (want.unsigned_value !== u || want.signed_value !== s || want.byte_count !== c) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: mismatch u exp %h got %h, s exp %h got %h, count exp %0d got %0d",
					$realtime, want.unsigned_value, u, want.signed_value, s,
					want.byte_count, c);
		end
	endfunction
endclass

module tb;

	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int PHASE_BYTES = 290;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] in_byte = 8'h00;
	logic [1:0] value_kind = vsd_pkg::KIND_U32;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [62:0] unsigned_value;
	logic signed [31:0] signed_value;
	logic [3:0] byte_count;

	varint_tracker book = new();

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int bytes_sent = 0;
	int idle_cycles = 0;
	bit hold_request = 1'b0;
	bit hold_seen = 1'b0;

	varint_sign_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.value_kind(value_kind),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.unsigned_value(unsigned_value),
		.signed_value(signed_value),
		.byte_count(byte_count)
	);

	always #5 clk = ~clk;

	// offer one request, with a random gap first, and wait for it to be taken
	task automatic offer_byte(input logic [7:0] b, input logic [1:0] k);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		value_kind <= k;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		book.take_byte(b, k);
		bytes_sent++;
	endtask

	// one well-formed value; fill 0 random data, 1 all zero, 2 all ones
	task automatic offer_value(input logic [1:0] k, input int len, input int fill);
		int lim;
		logic [7:0] b;
		lim = (k == vsd_pkg::KIND_U32) ? vsd_pkg::LIMIT_32 : vsd_pkg::LIMIT_64;
		for (int i = 0; i < len; i++) begin
			case (fill)
				1: b[6:0] = 7'h00;
				2: b[6:0] = 7'h7f;
				default: b[6:0] = 7'($urandom_range(127));
			endcase
			if (i < len - 1)
				b[7] = 1'b1;
			else if (i == lim - 1)
				b[7] = 1'($urandom_range(1));
			else
				b[7] = 1'b0;
			// kind only matters on the first byte, so scramble it on the rest
			offer_byte(b, (i == 0) ? k : 2'($urandom_range(3)));
		end
	endtask

	// one random unit: mostly well-formed values, some stray bytes
	task automatic offer_random_unit();
		int r;
		int lim;
		int len;
		int fill;
		logic [1:0] k;
		r = $urandom_range(99);
		if (r < 12) begin
			offer_byte(8'($urandom_range(255)), 2'($urandom_range(3)));
			return;
		end
		r = $urandom_range(99);
		k = (r < 30) ? vsd_pkg::KIND_U32 : (r < 60) ? vsd_pkg::KIND_U64 :
			(r < 92) ? vsd_pkg::KIND_S32 : KIND_SPARE;
		lim = (k == vsd_pkg::KIND_U32) ? vsd_pkg::LIMIT_32 : vsd_pkg::LIMIT_64;
		r = $urandom_range(99);
		len = (r < 50) ? $urandom_range(2, 1) : (r < 85) ? $urandom_range(lim, 1) : lim;
		r = $urandom_range(99);
		fill = (r < 10) ? 1 : (r < 20) ? 2 : 0;
		offer_value(k, len, fill);
	endtask

	// result side: check accepted values, stall at random, honour a long hold-off
	initial begin
		int hold_left;
		hold_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0)
				book.match_value(unsigned_value, signed_value, byte_count);
			if (hold_request && !hold_seen) begin
				hold_seen = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// watchdog on cycles with no request or result taken
	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("timeout: no progress for %0d cycles", IDLE_LIMIT);
		$display("FAIL varint_sign_decoder");
		$finish;
	end

	// stimulus and end of run
	initial begin
		int send_pct[4];
		int recv_pct[4];
		int target;
		send_pct = '{0, 56, 0, 30};
		recv_pct = '{0, 0, 56, 30};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, byte limits, kind 0 overflow, negative zero, spare kind
		offer_byte(8'h00, vsd_pkg::KIND_U32);
		offer_byte(8'h7f, vsd_pkg::KIND_U32);
		offer_value(vsd_pkg::KIND_U32, 5, 2);
		repeat (9) offer_byte(8'hff, vsd_pkg::KIND_U64);
		offer_byte(8'h01, vsd_pkg::KIND_S32);
		offer_byte(8'h03, vsd_pkg::KIND_S32);
		offer_byte(8'h81, vsd_pkg::KIND_S32);
		offer_byte(8'h01, vsd_pkg::KIND_U32);
		offer_byte(8'h55, KIND_SPARE);
		offer_byte(8'h80, vsd_pkg::KIND_U64);
		offer_byte(8'h00, vsd_pkg::KIND_S32);

		// random phases with different idle and stall mixes
		target = bytes_sent;
		for (int p = 0; p < 4; p++) begin
			send_idle_pct = send_pct[p];
			recv_stall_pct = recv_pct[p];
			target += PHASE_BYTES;
			while (bytes_sent < target) begin
				// long receiver hold-off while the sender keeps pushing
				if (p == 0 && !hold_request && bytes_sent > target - PHASE_BYTES / 2)
					hold_request = 1'b1;
				offer_random_unit();
			end
		end
		in_valid <= 1'b0;

		while (book.pending_values.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d bytes; decoded %0d u32, %0d u64, %0d s32, %0d spare-kind values",
			bytes_sent, book.kinds_seen[0], book.kinds_seen[1], book.kinds_seen[2],
			book.kinds_seen[3]);
		$display("%0d results checked, %0d mismatches", book.values_checked, book.mismatches);
		if (book.mismatches == 0 && book.pending_values.size() == 0)
			$display("PASS varint_sign_decoder");
		else
			$display("FAIL varint_sign_decoder");
		$finish;
	end

endmodule
